// ===== src/csb_pkg.sv =====
// shared constants and types for the categorical sample bucketer
// no dependencies; imported by csb_bucket_bank, categorical_sample_bucketer_core and tb

package csb_pkg;

  localparam int CATEGORIES  = 16;
  localparam int MAX_SAMPLES = 65536;

  localparam int CAT_W   = $clog2(CATEGORIES);
  localparam int PROB_W  = 16;
  localparam int SUM_W   = 21;
  localparam int CNT_W   = 16;
  localparam int SMP_W   = 16;
  localparam int CATO_W  = 4;

  // sample counter wraps at the smaller of MAX_SAMPLES and 2^16
  localparam int SAMPLE_WRAP = (MAX_SAMPLES < 65536) ? MAX_SAMPLES : 65536;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_PROB  = 1'b1;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 40;

  // control from the row logic to the count bank
  typedef struct packed {
    logic             clear;
    logic             bump;
    logic [CAT_W-1:0] cat;
  } bank_ctrl_t;

  // one result transaction, sample number in the low bits
  typedef struct packed {
    logic [CNT_W-1:0]  slot;
    logic [CATO_W-1:0] category;
    logic [SMP_W-1:0]  sample_number;
  } result_t;

endpackage

// ===== src/csb_bucket_bank.sv =====
// per-category bucket counters with saturating increment and bulk clear
// depends on csb_pkg

module csb_bucket_bank import csb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bank_ctrl_t       ctrl_i,
  output logic [CNT_W-1:0] slot_o
);

  logic [CNT_W-1:0] counts_q [CATEGORIES];
  logic [CNT_W-1:0] counts_d [CATEGORIES];

  assign slot_o = counts_q[ctrl_i.cat];

  always_comb begin
    for (int i = 0; i < CATEGORIES; i++) begin
      counts_d[i] = counts_q[i];
      if (ctrl_i.clear) begin
        counts_d[i] = '0;
      end else if (ctrl_i.bump && (ctrl_i.cat == CAT_W'(i)) && (counts_q[i] != '1)) begin
        counts_d[i] = counts_q[i] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CATEGORIES; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < CATEGORIES; i++) begin
        counts_q[i] <= counts_d[i];
      end
    end
  end

endmodule

// ===== src/categorical_sample_bucketer_core.sv =====
// top level of the categorical sample bucketer: row scan, sample counter, output skid
// depends on csb_pkg and csb_bucket_bank
// a result is registered in the result register, or in the skid while the receiver stalls
// throughput: one input transaction per cycle while the skid is empty; the row sum, compare and count update
//   for an element all settle between the row state registers and the result register
// a two-deep output (result register plus skid) keeps the input open while a result waits
// reset clears the bucket counts, sample counter, row state and the valid flags of both output stages at once

module categorical_sample_bucketer_core import csb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // slave side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // prob [15:0], uniform [31:16]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // cmd [0], first_of_row [1]
  input  logic                 s_axis_tlast,  // last_of_row
  // master side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata   // sample_number [15:0], category [19:16],
                                              // slot [35:20], zero [39:36]
);

  // input field unpacking
  logic [PROB_W-1:0] prob;
  logic [PROB_W-1:0] uniform;
  logic              cmd;
  logic              first_of_row;
  logic              last_of_row;

  assign prob         = s_axis_tdata[15:0];
  assign uniform      = s_axis_tdata[31:16];
  assign cmd          = s_axis_tuser[0];
  assign first_of_row = s_axis_tuser[1];
  assign last_of_row  = s_axis_tlast;

  // row state
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [PROB_W-1:0] held_q, held_d;
  logic [CAT_W-1:0]  pos_q, pos_d;
  logic [CAT_W-1:0]  chosen_q, chosen_d;
  logic              found_q, found_d;
  logic [SMP_W-1:0]  smp_q, smp_d;

  // output stages
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  logic accept;
  logic produce;
  logic out_free;

  // the input stalls only when both output stages are full
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // element scan: restart on first, add, find first crossing
  logic [SUM_W-1:0]  base_sum;
  logic [CAT_W-1:0]  base_pos;
  logic [CAT_W-1:0]  base_chosen;
  logic              base_found;
  logic [PROB_W-1:0] uni_eff;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_new;
  logic              hit;
  logic              found_new;
  logic [CAT_W-1:0]  chosen_new;
  logic [CAT_W-1:0]  cat_pick;

  always_comb begin
    base_sum    = first_of_row ? '0 : sum_q;
    base_pos    = first_of_row ? '0 : pos_q;
    base_chosen = first_of_row ? '0 : chosen_q;
    base_found  = first_of_row ? 1'b0 : found_q;
    uni_eff     = first_of_row ? uniform : held_q;

    // saturating Q5.16 accumulate
    sum_wide = {1'b0, base_sum} + (SUM_W + 1)'(prob);
    sum_new  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

    hit        = !base_found && (sum_new >= SUM_W'(uni_eff));
    found_new  = base_found || hit;
    chosen_new = hit ? base_pos : base_chosen;

    // sum never reached the uniform: fall back to this element's position
    cat_pick = found_new ? chosen_new : base_pos;
  end

  assign produce = accept && (cmd == CMD_PROB) && last_of_row;

  // bucket counts
  bank_ctrl_t       bank_ctrl;
  logic [CNT_W-1:0] slot;

  assign bank_ctrl.clear = accept && (cmd == CMD_CLEAR);
  assign bank_ctrl.bump  = produce;
  assign bank_ctrl.cat   = cat_pick;

  csb_bucket_bank u_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (bank_ctrl),
    .slot_o (slot)
  );

  // sample counter wrap
  logic [SMP_W:0] smp_inc;
  assign smp_inc = {1'b0, smp_q} + (SMP_W + 1)'(1);

  // result built from the current element
  result_t res_new;
  logic [CAT_W+CATO_W-1:0] cat_wide;

  assign cat_wide              = (CAT_W + CATO_W)'(cat_pick);
  assign res_new.sample_number = smp_q;
  assign res_new.category      = cat_wide[CATO_W-1:0];
  assign res_new.slot          = slot;

  // row state update
  always_comb begin
    sum_d    = sum_q;
    held_d   = held_q;
    pos_d    = pos_q;
    chosen_d = chosen_q;
    found_d  = found_q;
    smp_d    = smp_q;
    if (accept) begin
      if (cmd == CMD_CLEAR) begin
        // clear keeps the row state
        smp_d = '0;
      end else begin
        held_d = uni_eff;
        if (last_of_row) begin
          sum_d    = '0;
          pos_d    = '0;
          chosen_d = '0;
          found_d  = 1'b0;
          smp_d    = (smp_inc >= (SMP_W + 1)'(SAMPLE_WRAP)) ? '0 : smp_inc[SMP_W-1:0];
        end else begin
          sum_d    = sum_new;
          chosen_d = chosen_new;
          found_d  = found_new;
          // position sticks at the last category
          pos_d    = (base_pos < CAT_W'(CATEGORIES - 1)) ? base_pos + CAT_W'(1) : base_pos;
        end
      end
    end
  end

  // result register plus skid stage
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // input is stalled while the skid is full, so nothing new arrives here
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = produce;
        if (produce) begin
          out_d = res_new;
        end
      end
    end else if (produce) begin
      skid_d       = res_new;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q        <= '0;
      held_q       <= '0;
      pos_q        <= '0;
      chosen_q     <= '0;
      found_q      <= 1'b0;
      smp_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      sum_q        <= sum_d;
      held_q       <= held_d;
      pos_q        <= pos_d;
      chosen_q     <= chosen_d;
      found_q      <= found_d;
      smp_q        <= smp_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W - $bits(result_t))'(0), out_q};

endmodule

// ===== verif/tb.sv =====
// self-checking bench for categorical_sample_bucketer_core: directed table, then random rows
// depends on csb_pkg and the core; each result is checked against a local row classifier or a table value

`timescale 1ns / 100ps

module tb;
  import csb_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int HOLD_CYCLES = 300;
  localparam int SAT_ROWS    = 64;        // back to back single rows into bucket 0
  localparam int RAND_ITEMS  = 265;       // per idling phase, four phases
  localparam int DRAIN_LIMIT = 100000;
  localparam logic [SUM_W-1:0] SUM_TOP = '1;

  // one input element as the bench sees it
  typedef struct packed {
    logic              cmd;
    logic [PROB_W-1:0] prob;
    logic [PROB_W-1:0] uniform;
    logic              first;
    logic              last;
  } elem_t;

  // directed table row; want is used only when typed is set
  typedef struct packed {
    elem_t   e;
    logic    typed;
    result_t want;
  } dir_row_t;

  localparam result_t NO_WANT = '0;
  localparam int DIR_N = 20;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  categorical_sample_bucketer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // directed stimulus; typed rows carry results that follow straight from reset or clear state
  dir_row_t dir_tab [0:DIR_N-1] = '{
    // single element, zero uniform: category 0, first sample after reset
    '{'{CMD_PROB,  16'h0000, 16'h0000, 1'b1, 1'b1}, 1'b1, '{16'd0, 4'd0, 16'd0}},
    // single element, both fields at full scale: sum just reaches the uniform
    '{'{CMD_PROB,  16'hFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b1, '{16'd1, 4'd0, 16'd1}},
    // sum never reaches the uniform: category is the last element's position
    '{'{CMD_PROB,  16'h0000, 16'hFFFF, 1'b1, 1'b0}, 1'b0, NO_WANT},
    '{'{CMD_PROB,  16'h0000, 16'h0000, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{CMD_PROB,  16'h0000, 16'h0000, 1'b0, 1'b1}, 1'b1, '{16'd0, 4'd2, 16'd2}},
    // ordinary three element row, hit on the second element
    '{'{CMD_PROB,  16'h4000, 16'h8000, 1'b1, 1'b0}, 1'b0, NO_WANT},
    '{'{CMD_PROB,  16'h4000, 16'h0000, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{CMD_PROB,  16'hFFFF, 16'h0000, 1'b0, 1'b1}, 1'b0, NO_WANT},
    // clear with every other field set: ignored fields, no result
    '{'{CMD_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b0, NO_WANT},
    '{'{CMD_PROB,  16'h1234, 16'h0000, 1'b1, 1'b1}, 1'b1, '{16'd0, 4'd0, 16'd0}},
    // element with no first: held uniform and fresh row state carry on
    '{'{CMD_PROB,  16'h0000, 16'hFFFF, 1'b0, 1'b1}, 1'b0, NO_WANT},
    // clear in the middle of a row keeps the row going
    '{'{CMD_PROB,  16'h8000, 16'hC000, 1'b1, 1'b0}, 1'b0, NO_WANT},
    '{'{CMD_CLEAR, 16'h0000, 16'h0000, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{CMD_PROB,  16'h8000, 16'h0000, 1'b0, 1'b1}, 1'b0, NO_WANT},
    // one short of the uniform on a single element row
    '{'{CMD_PROB,  16'hFFFE, 16'hFFFF, 1'b1, 1'b1}, 1'b0, NO_WANT},
    // exact equality at the smallest nonzero uniform
    '{'{CMD_PROB,  16'h0001, 16'h0001, 1'b1, 1'b1}, 1'b0, NO_WANT},
    '{'{CMD_PROB,  16'h0000, 16'h0001, 1'b1, 1'b0}, 1'b0, NO_WANT},
    '{'{CMD_PROB,  16'h0001, 16'h0000, 1'b0, 1'b1}, 1'b0, NO_WANT},
    // a new first cuts off an unfinished row
    '{'{CMD_PROB,  16'h0000, 16'hFFFF, 1'b1, 1'b0}, 1'b0, NO_WANT},
    '{'{CMD_PROB,  16'h0000, 16'h0000, 1'b1, 1'b1}, 1'b0, NO_WANT}
  };

  // classifier state: bucket counts, row scan and sample counter
  logic [CNT_W-1:0] cnt_bank [CATEGORIES];
  logic [SUM_W-1:0] row_sum;
  logic [PROB_W-1:0] row_uniform;
  logic [CAT_W-1:0] row_pos;
  logic [CAT_W-1:0] row_pick;
  logic             row_hit;
  int               smp_count;

  result_t pending_results [$];
  int      fail_count = 0;

  // idling controls, written by the stimulus process only, but hold_active by the hold-off process
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_go   = 1'b0;
  bit hold_active = 1'b0;

  task automatic restart_row();
    row_sum  = '0;
    row_pos  = '0;
    row_pick = '0;
    row_hit  = 1'b0;
  endtask

  // inverse cdf step for one element; got is set when the row closes
  task automatic classify_element(input elem_t e, output bit got, output result_t r);
    logic [SUM_W:0] sum_ext;
    logic [CAT_W-1:0] cat;
    int nxt;
    got = 1'b0;
    r   = '0;
    if (e.cmd == CMD_CLEAR) begin
      foreach (cnt_bank[i]) cnt_bank[i] = '0;
      smp_count = 0;
      return;
    end
    if (e.first) begin
      restart_row();
      row_uniform = e.uniform;
    end
    // running sum saturates at the top of its 21 bits
    sum_ext = {1'b0, row_sum} + (SUM_W + 1)'(e.prob);
    row_sum = sum_ext[SUM_W] ? SUM_TOP : sum_ext[SUM_W-1:0];
    if (!row_hit && row_sum >= SUM_W'(row_uniform)) begin
      row_hit  = 1'b1;
      row_pick = row_pos;
    end
    if (!e.last) begin
      if (row_pos < CAT_W'(CATEGORIES - 1)) row_pos = row_pos + CAT_W'(1);
      return;
    end
    cat = row_hit ? row_pick : row_pos;
    r.sample_number = smp_count[SMP_W-1:0];
    r.category      = CATO_W'(cat);
    r.slot          = cnt_bank[cat];
    if (cnt_bank[cat] != '1) cnt_bank[cat] = cnt_bank[cat] + CNT_W'(1);
    nxt = smp_count + 1;
    if (nxt >= SAMPLE_WRAP) nxt = 0;
    smp_count = nxt;
    restart_row();
    got = 1'b1;
  endtask

  // offers one element, waits for the transaction, then records its expectation
  task automatic offer_element(input elem_t e, input bit typed, input result_t want);
    bit got;
    result_t r;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {e.uniform, e.prob};
    s_axis_tuser  <= {e.first, e.cmd};
    s_axis_tlast  <= e.last;
    do @(posedge clk_i); while (!s_axis_tready);
    classify_element(e, got, r);
    if (got) pending_results.push_back(typed ? want : r);
  endtask

  task automatic offer(input elem_t e);
    offer_element(e, 1'b0, NO_WANT);
  endtask

  // mostly spread around one full scale over the row, sometimes anything
  function automatic logic [PROB_W-1:0] draw_prob(int len);
    int hi;
    if ($urandom_range(0, 3) == 0) return PROB_W'($urandom);
    hi = 131072 / len;
    if (hi > 65535) hi = 65535;
    return PROB_W'($urandom_range(0, hi));
  endfunction

  // random traffic: mostly well-formed rows, plus clears, noise and broken rows
  task automatic random_traffic(input int n);
    int count;
    int pick;
    int len;
    logic [PROB_W-1:0] uni;
    elem_t e;
    count = 0;
    while (count < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // long rows run past the last category and can overflow the sum
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        uni = PROB_W'($urandom);
        for (int k = 0; k < len; k++) begin
          e = '{CMD_PROB, draw_prob(len), (k == 0) ? uni : PROB_W'($urandom),
                k == 0, k == len - 1};
          offer(e);
          count++;
        end
      end else if (pick < 78) begin
        e = '{CMD_CLEAR, PROB_W'($urandom), PROB_W'($urandom),
              1'($urandom), 1'($urandom)};
        offer(e);
        count++;
      end else if (pick < 90) begin
        e = '{($urandom_range(0, 7) == 0) ? CMD_CLEAR : CMD_PROB, PROB_W'($urandom),
              PROB_W'($urandom), 1'($urandom), 1'($urandom)};
        offer(e);
        count++;
      end else begin
        // row that stops without a last and sometimes lacks its first
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          e = '{CMD_PROB, draw_prob(len), PROB_W'($urandom),
                (k == 0) && ($urandom_range(0, 1) == 1), 1'b0};
          offer(e);
          count++;
        end
      end
    end
  endtask

  // long receiver hold-off, counted here so the core fills up and stalls its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active = 1'b0;
  end

  // master side ready, changed at the falling edge
  always @(negedge clk_i) begin
    m_axis_tready <= hold_active ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic void report(string field, int want, int got);
    $display("%0t ns: %s expected %0d got %0d", $time, field, want, got);
  endfunction

  // result checker: each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(result_t)-1:0];
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none got sample %0d cat %0d slot %0d",
                 $time, got.sample_number, got.category, got.slot);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.sample_number !== want.sample_number) begin
          report("sample_number", want.sample_number, got.sample_number);
          fail_count++;
        end
        if (got.category !== want.category) begin
          report("category", want.category, got.category);
          fail_count++;
        end
        if (got.slot !== want.slot) begin
          report("slot", want.slot, got.slot);
          fail_count++;
        end
        if (m_axis_tdata[M_TDATA_W-1:$bits(result_t)] !== '0) begin
          report("pad", 0, m_axis_tdata[M_TDATA_W-1:$bits(result_t)]);
          fail_count++;
        end
      end
    end
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("categorical_sample_bucketer_core: mismatch");
    $finish;
  end

  // main sequence
  initial begin
    int guard;
    elem_t e;
    foreach (cnt_bank[i]) cnt_bank[i] = '0;
    row_uniform = '0;
    smp_count   = 0;
    restart_row();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      offer_element(dir_tab[i].e, dir_tab[i].typed, dir_tab[i].want);
    end

    // back to back single rows into category 0
    for (int i = 0; i < SAT_ROWS; i++) begin
      e = '{CMD_PROB, PROB_W'($urandom), '0, 1'b1, 1'b1};
      offer(e);
    end
    e = '{CMD_CLEAR, '0, '0, 1'b0, 1'b0};
    offer(e);

    // no idling, with the long hold-off at the start
    hold_go = 1'b1;
    random_traffic(RAND_ITEMS);
    // sender idle
    idle_pct = 69;
    random_traffic(RAND_ITEMS);
    // receiver stalling
    idle_pct  = 0;
    stall_pct = 69;
    random_traffic(RAND_ITEMS);
    // both
    idle_pct  = 32;
    stall_pct = 32;
    random_traffic(RAND_ITEMS);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    stall_pct = 0;

    // drain, then allow for the output latency
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, pending_results.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("categorical_sample_bucketer_core: match");
    end else begin
      $display("categorical_sample_bucketer_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/csb_pkg.sv
src/csb_bucket_bank.sv
src/categorical_sample_bucketer_core.sv
verif/tb.sv
